@@ rtl/chacha20_keystream_xor_top_macros.svh @@
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR assertion macros
// Shared concurrent assertion forms used by the RTL of the cipher block.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_XOR_TOP_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cc20: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cc20: next-cycle check failed");

`endif

@@ rtl/cc20_pkg.sv @@
// ----------------------------------------------------------------------------
// ChaCha20 package
// Types, constants and state encodings shared by the ChaCha20 XOR block.
// ----------------------------------------------------------------------------
package cc20_pkg;

    // Data path geometry.
    localparam int DATA_BYTES   = 8;
    localparam int WORD_BITS    = 64;
    localparam int BYTE_CNT_W   = 4;
    localparam int LANE_IDX_W   = $clog2(DATA_BYTES);
    localparam int BLOCK_BYTES  = 64;
    localparam int BLOCK_WORDS  = 16;
    localparam int POS_W        = $clog2(BLOCK_BYTES + 1);
    localparam int KS_BITS      = BLOCK_BYTES * 8;

    // Round structure: ten double rounds, one round per cycle.
    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(ROUNDS);
    localparam int LANES         = 4;

    // Quarter-round rotation distances.
    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    typedef logic [31:0] word_t;

    // "expand 32-byte k"
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    typedef logic [BLOCK_WORDS-1:0][31:0] block_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [2:0] {
        REG_KEY0       = 3'd0,
        REG_KEY1       = 3'd1,
        REG_KEY2       = 3'd2,
        REG_KEY3       = 3'd3,
        REG_NONCE_LO   = 3'd4,
        REG_NONCE_HI   = 3'd5,
        REG_INIT_COUNT = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XOR,
        ST_GEN
    } word_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } core_state_t;

endpackage

@@ rtl/cc20_qround.sv @@
// ----------------------------------------------------------------------------
// ChaCha20 quarter round
// One lane of the round function: the full add, xor, rotate sequence.
// ----------------------------------------------------------------------------
module cc20_qround (
    input  cc20_pkg::quad_t quad,
    output cc20_pkg::quad_t mixed
);
    import cc20_pkg::*;

    function automatic word_t rotl(word_t x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    word_t a1, b1, c1, d1;
    word_t a2, b2, c2, d2;

    assign a1 = quad.a + quad.b;
    assign d1 = rotl(quad.d ^ a1, ROT_A);
    assign c1 = quad.c + d1;
    assign b1 = rotl(quad.b ^ c1, ROT_B);
    assign a2 = a1 + b1;
    assign d2 = rotl(d1 ^ a2, ROT_C);
    assign c2 = c1 + d2;
    assign b2 = rotl(b1 ^ c2, ROT_D);

    assign mixed = '{a: a2, b: b2, c: c2, d: d2};

endmodule

@@ rtl/cc20_core.sv @@
// ----------------------------------------------------------------------------
// ChaCha20 block core
// Four quarter-round lanes run one round per cycle; the merge stage routes
// lane results back into column or diagonal positions and adds the input.
// ----------------------------------------------------------------------------
module cc20_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [3:0][63:0]        key,
    input  logic [63:0]             nonce_lo,
    input  logic [31:0]             nonce_hi,
    input  logic [31:0]             count,
    input  logic                    start,
    output cc20_pkg::core_stat_t    stat,
    output cc20_pkg::block_t        keystream
);
    import cc20_pkg::*;

    core_state_t          state_reg, state_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    block_t               work_reg, work_next;
    block_t               init;
    logic                 load;
    logic                 step;
    logic                 column;

    quad_t                lane_in  [LANES];
    quad_t                lane_out [LANES];
    word_t                col_out  [BLOCK_WORDS];
    word_t                dia_out  [BLOCK_WORDS];

    // Initial block state: constants, key, counter, nonce.
    always_comb
    begin
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = key[i][31:0];
            init[5 + 2 * i] = key[i][63:32];
        end
        init[12] = count;
        init[13] = nonce_lo[31:0];
        init[14] = nonce_lo[63:32];
        init[15] = nonce_hi;
    end

    // Even rounds work on columns, odd rounds on diagonals.
    assign column = ~rnd_reg[0];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        localparam int IB = 4 + ((l + 1) % 4);
        localparam int IC = 8 + ((l + 2) % 4);
        localparam int ID = 12 + ((l + 3) % 4);

        assign lane_in[l] = column ?
            quad_t'{a: work_reg[l], b: work_reg[4 + l], c: work_reg[8 + l],
                    d: work_reg[12 + l]} :
            quad_t'{a: work_reg[l], b: work_reg[IB], c: work_reg[IC], d: work_reg[ID]};

        cc20_qround u_qround (
            .quad  (lane_in[l]),
            .mixed (lane_out[l])
        );

        assign col_out[l]      = lane_out[l].a;
        assign col_out[4 + l]  = lane_out[l].b;
        assign col_out[8 + l]  = lane_out[l].c;
        assign col_out[12 + l] = lane_out[l].d;

        assign dia_out[l]  = lane_out[l].a;
        assign dia_out[IB] = lane_out[l].b;
        assign dia_out[IC] = lane_out[l].c;
        assign dia_out[ID] = lane_out[l].d;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (start)
                begin
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = CORE_FINAL;
                end
            end
            CORE_FINAL:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        load      = 1'b0;
        step      = 1'b0;
        stat.busy = 1'b0;
        stat.done = 1'b0;
        unique case (state_reg)
            CORE_IDLE:
            begin
                load = start;
            end
            CORE_ROUND:
            begin
                step      = 1'b1;
                stat.busy = 1'b1;
            end
            CORE_FINAL:
            begin
                stat.busy = 1'b1;
                stat.done = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        work_next = work_reg;
        rnd_next  = rnd_reg;
        if (load)
        begin
            work_next = init;
            rnd_next  = '0;
        end
        else if (step)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                work_next[i] = column ? col_out[i] : dia_out[i];
            end
            rnd_next = rnd_reg + RND_W'(1);
        end
    end

    // Feed-forward add; sampled by the owner while done is high.
    always_comb
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            keystream[i] = work_reg[i] + init[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule

@@ rtl/chacha20_keystream_xor_top.sv @@
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR top level
// Encrypts or decrypts a message word by word with the ChaCha20 keystream.
// ----------------------------------------------------------------------------
// Usage:
//   Write key, nonce and initial block count through the cfg_write port while
//   no word is in flight. Message words enter on the in_valid/in_ready
//   channel, eight bytes each, byte 0 in the low bits; valid_bytes gives the
//   meaningful bytes (values above eight count as eight) and last_word closes
//   the message. Results leave on out_valid/out_ready with unused bytes zero.
//   When the keystream buffer holds its bytes, an accepted word is
//   registered, XORed in ST_XOR and loaded into the output register; the
//   engine then returns to ST_IDLE and takes the next word. Each new 64-byte
//   block is made in steps: the core is started, runs 20 rounds on four
//   quarter-round lanes and ends with one feed-forward add. One word is
//   worked on at a time; in_ready is high only when the word engine is free.
//   A word may straddle a block boundary after a short word. Reset clears
//   the configuration registers and the counter and empties the buffer; the
//   first word after reset or after a last word starts a new message at the
//   initial count. If the receiver stalls, the result waits in the output
//   register, the next word may still be taken, and it then waits until that
//   register is free.
// ----------------------------------------------------------------------------
`include "chacha20_keystream_xor_top_macros.svh"

module chacha20_keystream_xor_top (
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration port
    input  logic                    cfg_write,
    input  cc20_pkg::cfg_index_t    cfg_index,
    input  logic [63:0]             cfg_data,
    // Input channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [63:0]             data_word,
    input  logic [3:0]              valid_bytes,
    input  logic                    last_word,
    // Output channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [63:0]             result_word,
    output logic [3:0]              result_bytes,
    output logic                    result_last
);
    import cc20_pkg::*;

    // Configuration registers.
    logic [3:0][63:0]           key_reg, key_next;
    logic [63:0]                nonce_lo_reg, nonce_lo_next;
    logic [31:0]                nonce_hi_reg, nonce_hi_next;
    logic [31:0]                init_count_reg, init_count_next;

    // Message and word state.
    word_state_t                state_reg, state_next;
    logic                       mid_msg_reg, mid_msg_next;
    logic [31:0]                block_count_reg, block_count_next;
    logic [BYTE_CNT_W-1:0]      need_reg, need_next;
    logic [BYTE_CNT_W-1:0]      done_reg, done_next;
    logic                       last_reg, last_next;
    logic [WORD_BITS-1:0]       data_reg, data_next;
    logic [WORD_BITS-1:0]       res_reg, res_next;

    // Keystream buffer: byte 0 is the next unused keystream byte.
    logic [KS_BITS-1:0]         ks_buf_reg, ks_buf_next;
    logic [POS_W-1:0]           ks_left_reg, ks_left_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]       out_word_reg, out_word_next;
    logic [BYTE_CNT_W-1:0]      out_bytes_reg, out_bytes_next;
    logic                       out_last_reg, out_last_next;

    // Control.
    logic                       accept;
    logic                       core_start;
    logic                       out_load;
    logic                       out_free;
    logic                       need_gen;
    logic                       finish;
    logic [BYTE_CNT_W-1:0]      remain;
    logic [BYTE_CNT_W-1:0]      take;
    logic [BYTE_CNT_W-1:0]      done_k;
    logic [BYTE_CNT_W-1:0]      clamp_bytes;
    logic [DATA_BYTES-1:0]      lane_en;
    logic [DATA_BYTES-1:0][7:0] lane_byte;
    logic [DATA_BYTES-1:0][7:0] ks_head;
    logic [WORD_BITS-1:0]       res_pass;

    core_stat_t                 core_stat;
    block_t                     keystream;

    // ------------------------------------------------------------------
    // Configuration decode.
    // ------------------------------------------------------------------
    always_comb
    begin
        key_next        = key_reg;
        nonce_lo_next   = nonce_lo_reg;
        nonce_hi_next   = nonce_hi_reg;
        init_count_next = init_count_reg;
        if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                begin
                    key_next[cfg_index[1:0]] = cfg_data;
                end
                REG_NONCE_LO:
                begin
                    nonce_lo_next = cfg_data;
                end
                REG_NONCE_HI:
                begin
                    nonce_hi_next = cfg_data[31:0];
                end
                REG_INIT_COUNT:
                begin
                    init_count_next = cfg_data[31:0];
                end
                default:
                begin
                    // Indexes beyond the register list are ignored.
                    init_count_next = init_count_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Block generator: four quarter-round lanes plus feed-forward. The counter
    // stays still as it runs; the user must freeze configuration, unenforced.
    // ------------------------------------------------------------------
    cc20_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .nonce_lo  (nonce_lo_reg),
        .nonce_hi  (nonce_hi_reg),
        .count     (block_count_reg),
        .start     (core_start),
        .stat      (core_stat),
        .keystream (keystream)
    );

    // ------------------------------------------------------------------
    // Byte pass. Each cycle in ST_XOR consumes as many bytes as both the
    // word and the buffer still have; when the buffer is empty, take is
    // zero and the pass changes nothing.
    // ------------------------------------------------------------------
    assign clamp_bytes = (valid_bytes > BYTE_CNT_W'(DATA_BYTES)) ?
                         BYTE_CNT_W'(DATA_BYTES) : valid_bytes;
    assign remain   = need_reg - done_reg;
    assign take     = (ks_left_reg < POS_W'(remain)) ?
                      ks_left_reg[BYTE_CNT_W-1:0] : remain;
    assign done_k   = done_reg + take;
    assign ks_head  = ks_buf_reg[DATA_BYTES*8-1:0];
    assign out_free = ~out_valid_reg | out_ready;
    assign need_gen = (ks_left_reg == '0) && (remain != '0);
    assign finish   = (done_k == need_reg);

    for (genvar j = 0; j < DATA_BYTES; j++)
    begin : g_byte
        localparam logic [BYTE_CNT_W-1:0] LANE = BYTE_CNT_W'(j);
        logic [BYTE_CNT_W-1:0] offs;

        // Word byte j pairs with buffer byte j - done.
        assign offs         = LANE - done_reg;
        assign lane_en[j]   = (LANE >= done_reg) && (LANE < done_k);
        assign lane_byte[j] = data_reg[8 * j +: 8] ^ ks_head[offs[LANE_IDX_W-1:0]];
        assign res_pass[8 * j +: 8] = lane_en[j] ? lane_byte[j] : res_reg[8 * j +: 8];
    end

    // ------------------------------------------------------------------
    // Word state machine.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_XOR;
                end
            end
            ST_XOR:
            begin
                if (need_gen)
                begin
                    state_next = ST_GEN;
                end
                else if (finish && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GEN:
            begin
                if (core_stat.done)
                begin
                    state_next = ST_XOR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        core_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_XOR:
            begin
                core_start = need_gen;
                out_load   = ~need_gen & finish & out_free;
            end
            ST_GEN:
            begin
                core_start = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid & in_ready;

    // ------------------------------------------------------------------
    // Data path next values.
    // ------------------------------------------------------------------
    always_comb
    begin
        mid_msg_next     = mid_msg_reg;
        block_count_next = block_count_reg;
        need_next        = need_reg;
        done_next        = done_reg;
        last_next        = last_reg;
        data_next        = data_reg;
        res_next         = res_reg;
        ks_buf_next      = ks_buf_reg;
        ks_left_next     = ks_left_reg;

        if (accept)
        begin
            data_next    = data_word;
            need_next    = clamp_bytes;
            last_next    = last_word;
            done_next    = '0;
            res_next     = '0;
            mid_msg_next = ~last_word;
            // A new message restarts the counter and drops leftover keystream.
            if (!mid_msg_reg)
            begin
                block_count_next = init_count_reg;
                ks_left_next     = '0;
            end
        end

        if (state_reg == ST_XOR)
        begin
            res_next     = res_pass;
            done_next    = done_k;
            ks_left_next = ks_left_reg - POS_W'(take);
            ks_buf_next  = ks_buf_reg >> {take, 3'b000};
        end

        if (core_stat.done)
        begin
            ks_buf_next      = keystream;
            ks_left_next     = POS_W'(BLOCK_BYTES);
            block_count_next = block_count_reg + 32'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_bytes_next = out_bytes_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res_pass;
            out_bytes_next = need_reg;
            out_last_next  = last_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg         <= '0;
            nonce_lo_reg    <= '0;
            nonce_hi_reg    <= '0;
            init_count_reg  <= '0;
            state_reg       <= ST_IDLE;
            mid_msg_reg     <= 1'b0;
            block_count_reg <= '0;
            need_reg        <= '0;
            done_reg        <= '0;
            ks_left_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            key_reg         <= key_next;
            nonce_lo_reg    <= nonce_lo_next;
            nonce_hi_reg    <= nonce_hi_next;
            init_count_reg  <= init_count_next;
            state_reg       <= state_next;
            mid_msg_reg     <= mid_msg_next;
            block_count_reg <= block_count_next;
            need_reg        <= need_next;
            done_reg        <= done_next;
            ks_left_reg     <= ks_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        data_reg      <= data_next;
        res_reg       <= res_next;
        ks_buf_reg    <= ks_buf_next;
        out_word_reg  <= out_word_next;
        out_bytes_reg <= out_bytes_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_word  = out_word_reg;
    assign result_bytes = out_bytes_reg;
    assign result_last  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CC20_ASSERT_NOW(a_done_within_need, clk, rst_n, state_reg != ST_IDLE, done_reg <= need_reg)
    `CC20_ASSERT_NEXT(a_load_frees_engine, clk, rst_n, out_load, state_reg == ST_IDLE)
    `CC20_ASSERT_NEXT(a_block_fills_buffer, clk, rst_n, core_stat.done, ks_left_reg == POS_W'(BLOCK_BYTES))
    `CC20_ASSERT_NOW(a_no_accept_while_gen, clk, rst_n, core_stat.busy, !in_ready)

endmodule

@@ tb/tb_chacha20_keystream_xor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR testbench
// Drives message words through the cipher block under changing keys, nonces
// and start counts. An independent ChaCha20 predictor computes each expected
// result word, and a monitor compares every delivered word field by field.
// ----------------------------------------------------------------------------
module tb_chacha20_keystream_xor_top;

    import cc20_pkg::*;

    // One message word as offered on the input channel.
    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
    } msg_word_t;

    // One cipher word as it should leave the output channel.
    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } cipher_word_t;

    // How the receiver paces out_ready during a phase.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_BURSTY
    } ready_style_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic         clk;
    logic         rst_n       = 1'b0;
    logic         cfg_write   = 1'b0;
    cfg_index_t   cfg_index   = REG_KEY0;
    logic [63:0]  cfg_data    = '0;
    logic         in_valid    = 1'b0;
    logic         in_ready;
    logic [63:0]  data_word   = '0;
    logic [3:0]   valid_bytes = 4'd8;
    logic         last_word   = 1'b0;
    logic         out_valid;
    logic         out_ready   = 1'b0;
    logic [63:0]  result_word;
    logic [3:0]   result_bytes;
    logic         result_last;

    chacha20_keystream_xor_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_word    (data_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_word  (result_word),
        .result_bytes (result_bytes),
        .result_last  (result_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the
    // keystream position, advanced once for every accepted word.
    // ------------------------------------------------------------------
    logic [63:0]  key_copy [4] = '{default: '0};
    logic [63:0]  nonce_lo_copy   = '0;
    word_t        nonce_hi_copy   = '0;
    word_t        start_count_copy = '0;

    word_t        next_count = '0;
    block_t       ks_block   = '0;
    logic [5:0]   ks_pos     = '0;
    logic         in_message = 1'b0;

    msg_word_t    pending_words [$];
    cipher_word_t expected_cipher [$];
    msg_word_t    offered;

    int           mismatch_count  = 0;
    int           words_sent      = 0;
    int           words_checked   = 0;
    int           blocks_made     = 0;
    int           settings_used   = 0;

    // Sender and receiver pacing, set per phase by the main sequence.
    int           gap_max    = 0;
    int           gap_left   = 0;
    int           burst_left = 1;
    ready_style_t rx_style   = RX_ALWAYS;
    int           rx_run     = 0;
    int           rx_stall   = 0;

    // One ChaCha20 quarter round on four state words.
    function automatic quad_t quarter_round(input quad_t q);
        quad_t r;
        r = q;
        r.a = r.a + r.b; r.d = r.d ^ r.a; r.d = {r.d[31-ROT_A:0], r.d[31:32-ROT_A]};
        r.c = r.c + r.d; r.b = r.b ^ r.c; r.b = {r.b[31-ROT_B:0], r.b[31:32-ROT_B]};
        r.a = r.a + r.b; r.d = r.d ^ r.a; r.d = {r.d[31-ROT_C:0], r.d[31:32-ROT_C]};
        r.c = r.c + r.d; r.b = r.b ^ r.c; r.b = {r.b[31-ROT_D:0], r.b[31:32-ROT_D]};
        return r;
    endfunction

    // Full 64-byte keystream block for the given counter, using the key
    // and nonce as currently programmed.
    function automatic block_t keystream_block(input word_t count);
        word_t  init [16];
        word_t  x    [16];
        block_t ks;
        int     i;
        int     c;
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        for (i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = key_copy[i][31:0];
            init[5 + 2 * i] = key_copy[i][63:32];
        end
        init[12] = count;
        init[13] = nonce_lo_copy[31:0];
        init[14] = nonce_lo_copy[63:32];
        init[15] = nonce_hi_copy;
        x = init;
        for (i = 0; i < DOUBLE_ROUNDS; i++)
        begin
            // Column round, then diagonal round.
            for (c = 0; c < 4; c++)
            begin
                {x[c], x[4 + c], x[8 + c], x[12 + c]} =
                    quarter_round({x[c], x[4 + c], x[8 + c], x[12 + c]});
            end
            for (c = 0; c < 4; c++)
            begin
                {x[c], x[4 + (c + 1) % 4], x[8 + (c + 2) % 4], x[12 + (c + 3) % 4]} =
                    quarter_round({x[c], x[4 + (c + 1) % 4], x[8 + (c + 2) % 4],
                                   x[12 + (c + 3) % 4]});
            end
        end
        for (i = 0; i < BLOCK_WORDS; i++)
        begin
            ks[i] = x[i] + init[i];
        end
        return ks;
    endfunction

    // Advances the keystream by the meaningful bytes of one word and
    // returns the cipher word the block should produce for it.
    function automatic cipher_word_t encrypt_word(input msg_word_t w);
        cipher_word_t r;
        logic [3:0]   n;
        int           i;
        n = (w.nbytes > 4'(DATA_BYTES)) ? 4'(DATA_BYTES) : w.nbytes;
        r.word   = '0;
        r.nbytes = n;
        r.last   = w.last;
        // A message picks up the start count on its first word.
        if (!in_message)
        begin
            next_count = start_count_copy;
            ks_pos     = '0;
            in_message = 1'b1;
        end
        for (i = 0; i < int'(n); i++)
        begin
            // A fresh block is made at the byte where the old one runs out,
            // which may fall inside a word after a short word.
            if (ks_pos == 6'd0)
            begin
                ks_block   = keystream_block(next_count);
                next_count = next_count + 32'd1;
                blocks_made++;
            end
            r.word[8 * i +: 8] = w.data[8 * i +: 8] ^ ks_block[ks_pos[5:2]][{ks_pos[1:0], 3'b000} +: 8];
            ks_pos = ks_pos + 6'd1;
        end
        if (w.last)
        begin
            in_message = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Register mirror: follows the write port exactly as the block sees it.
    // Narrow registers keep only their low 32 bits.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cfg_write)
        begin
            case (cfg_index)
                REG_KEY0:       key_copy[0]      = cfg_data;
                REG_KEY1:       key_copy[1]      = cfg_data;
                REG_KEY2:       key_copy[2]      = cfg_data;
                REG_KEY3:       key_copy[3]      = cfg_data;
                REG_NONCE_LO:   nonce_lo_copy    = cfg_data;
                REG_NONCE_HI:   nonce_hi_copy    = cfg_data[31:0];
                REG_INIT_COUNT: start_count_copy = cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers pending words in bursts with random gaps. A word that
    // is accepted at this edge is predicted before the next one is offered.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_cipher.push_back(encrypt_word(offered));
                words_sent++;
            end
            // The slot is free when nothing was offered or it was just taken.
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    offered = pending_words.pop_front();
                    data_word   <= offered.data;
                    valid_bytes <= offered.nbytes;
                    last_word   <= offered.last;
                    in_valid    <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, gap_max);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each delivered word against the oldest expectation,
    // then chooses out_ready for the next cycle from the phase's style.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cipher_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cipher.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with nothing expected", result_word));
            end
            else
            begin
                want = expected_cipher.pop_front();
                if (result_word !== want.word)
                begin
                    report_mismatch($sformatf("word %0d: result_word %h, expected %h",
                                              words_checked, result_word, want.word));
                end
                if (result_bytes !== want.nbytes)
                begin
                    report_mismatch($sformatf("word %0d: result_bytes %0d, expected %0d",
                                              words_checked, result_bytes, want.nbytes));
                end
                if (result_last !== want.last)
                begin
                    report_mismatch($sformatf("word %0d: result_last %b, expected %b",
                                              words_checked, result_last, want.last));
                end
                words_checked++;
            end
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_COIN:   out_ready <= ($urandom_range(0, 2) != 0);
                default:
                begin
                    // Runs of ready cycles broken by stalls.
                    if (rx_run > 0)
                    begin
                        rx_run--;
                        out_ready <= 1'b1;
                    end
                    else if (rx_stall > 0)
                    begin
                        rx_stall--;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        rx_run   = $urandom_range(1, 12);
                        rx_stall = $urandom_range(1, 20);
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Main sequence helpers.
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [63:0] data, input logic [3:0] nbytes,
                              input logic last);
        msg_word_t w;
        w.data   = data;
        w.nbytes = nbytes;
        w.last   = last;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_settings(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] k2, input logic [63:0] k3,
                                  input logic [63:0] nlo, input logic [63:0] nhi,
                                  input logic [63:0] count);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_NONCE_LO, nlo);
        write_reg(REG_NONCE_HI, nhi);
        write_reg(REG_INIT_COUNT, count);
        settings_used++;
    endtask

    // Holds the sequence until every queued word has gone in and every
    // expected result word has come back.
    task automatic wait_drained;
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_cipher.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    // Whole messages with random content. Most words are full; the last
    // word carries 1 to 8 bytes, and now and then any word gets an odd
    // byte count (zero, short, or above eight) as noise.
    task automatic queue_random_messages(input int n_words);
        int queued;
        int len;
        int w;
        logic [3:0] nb;
        queued = 0;
        while (queued < n_words)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 12);
            for (w = 0; w < len; w++)
            begin
                nb = (w == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
                if ($urandom_range(0, 11) == 0)
                begin
                    nb = 4'($urandom_range(0, 15));
                end
                queue_word(rand64(), nb, w == len - 1);
            end
            queued += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed words, then random phases each under
    // its own register setting and pacing. Registers change only while the
    // block is drained, so every phase boundary also pauses the sender
    // until all expected results have arrived.
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        int phase;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // Directed words under the reset setting (zero key, nonce, count).
        gap_max  = 2;
        rx_style = RX_COIN;
        queue_word(64'h0, 4'd8, 1'b0);
        queue_word({64{1'b1}}, 4'd8, 1'b0);
        // A word with no valid bytes consumes no keystream.
        queue_word(rand64(), 4'd0, 1'b0);
        // A short word in mid-message shifts all later words off alignment.
        queue_word(rand64(), 4'd3, 1'b0);
        for (i = 0; i < 5; i++)
        begin
            queue_word(rand64(), 4'd8, 1'b0);
        end
        // Above eight counts as eight; this word straddles a block boundary.
        queue_word(rand64(), 4'd12, 1'b0);
        queue_word(rand64(), 4'd5, 1'b1);
        // A message made of one empty last word, then a one-word message
        // with the widest byte count.
        queue_word(rand64(), 4'd0, 1'b1);
        queue_word(rand64(), 4'd15, 1'b1);
        wait_drained();

        // All-ones key and nonce with the count at its top, so the counter
        // wraps to zero on the second block of the next message.
        apply_settings({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                       {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        rx_style = RX_BURSTY;
        queue_word(rand64(), 4'd8, 1'b0);
        wait_drained();
        // Mid-message writes: the key change shows up at the next block,
        // the start count only at the next message.
        write_reg(REG_KEY2, rand64());
        write_reg(REG_INIT_COUNT, 64'h5);
        for (i = 0; i < 8; i++)
        begin
            queue_word(rand64(), 4'd8, i == 7);
        end
        queue_word(rand64(), 4'd8, 1'b1);
        wait_drained();

        // Random phases.
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    apply_settings(rand64(), rand64(), rand64(), rand64(),
                                   rand64(), rand64(), rand64());
                    gap_max  = 6;
                    rx_style = RX_COIN;
                end
                1:
                begin
                    // No idling on either side, counter about to wrap.
                    apply_settings({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                                   {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
                    gap_max  = 0;
                    rx_style = RX_ALWAYS;
                end
                2:
                begin
                    apply_settings('0, '0, '0, '0, '0, '0, '0);
                    gap_max  = 12;
                    rx_style = RX_BURSTY;
                end
                3:
                begin
                    apply_settings(rand64(), rand64(), rand64(), rand64(),
                                   rand64(), rand64(), {32'($urandom), 32'hFFFF_FFFE});
                    gap_max  = 3;
                    rx_style = RX_BURSTY;
                end
                4:
                begin
                    apply_settings(rand64(), rand64(), rand64(), rand64(),
                                   rand64(), rand64(), rand64());
                    gap_max  = 8;
                    rx_style = RX_COIN;
                end
                default:
                begin
                    apply_settings(rand64(), rand64(), rand64(), rand64(),
                                   rand64(), rand64(), rand64());
                    gap_max  = 2;
                    rx_style = RX_ALWAYS;
                end
            endcase
            @(negedge clk);
            queue_random_messages(200);
            wait_drained();
        end

        // Let any stray output word show up before the verdict.
        repeat (30) @(posedge clk);
        if (expected_cipher.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_cipher.size()));
        end

        $display("Covered %0d words sent and %0d checked under %0d register settings.",
                 words_sent, words_checked, settings_used);
        $display("Predicted %0d keystream blocks; %0d mismatches found.",
                 blocks_made, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop in case the block stops answering a handshake.
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d words pending and %0d results outstanding.",
                 pending_words.size(), expected_cipher.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
